>>> sv/lru_page_replacement_assert.svh
// ----------------------------------------------------------------------------
// lru_page_replacement_assert.svh
// assertion macros used by the lru page replacement checker
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// implication checked at every clock edge out of reset
`define LRUPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru page replacement check failed");

// signal holds on the cycle after a stalled transfer
`define LRUPR_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("lru page replacement check failed");

`endif

>>> sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// constants and field layout for the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W     = 16;
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // out_tuser bit positions
  localparam int TUSER_HIT   = 0;
  localparam int TUSER_EVICT = 1;

  // out_tdata field positions
  localparam int SLOT_LSB = 0;
  localparam int EVP_LSB  = SLOT_LSB + SLOT_W;
  localparam int EVP_MSB  = EVP_LSB + PAGE_W - 1;
  localparam int FC_LSB   = EVP_MSB + 1;
  localparam int FC_MSB   = FC_LSB + COUNT_W - 1;

endpackage

>>> sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page replacement over a small frame set, one page reference per transfer
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | content
//  in_     | in  | in_tvalid / in_tready   | page number, tlast ends the string
//  out_    | out | out_tvalid / out_tready | hit, slot, evicted page, fault count
//  cfg_    | in  | cfg_valid / cfg_ready   | frames_in_use
//
//  one reference per cycle unless the output stalls: tag compare, rank update
//  and result all happen in the input transfer's cycle. the output register is
//  the only stage; input is taken when it is empty or its result is taken in
//  the same cycle. rst_n clears frames, ranks, fault count and sets
//  frames_in_use to 8. a transfer with tlast clears the frames after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // page_number
  input  logic                   in_tlast,   // last_reference
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // frame_slot, evicted_page, fault_count, zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // hit, evicted_valid
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data    // frames_in_use
);

  localparam int PW   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int RW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNTW = $clog2(FRAMES + 1);
  localparam int CAPW = (CNTW > CFG_W) ? CNTW : CFG_W;

  logic [PW-1:0]      page_r   [FRAMES];
  logic [PW-1:0]      page_nxt [FRAMES];
  logic [RW-1:0]      rank_r   [FRAMES];
  logic [RW-1:0]      rank_nxt [FRAMES];
  logic [FRAMES-1:0]  valid_r, valid_nxt;
  logic [COUNT_W-1:0] faults_r, faults_nxt;
  logic [CFG_W-1:0]   cap_cfg_r;

  logic               out_valid_r;
  logic               out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [PAGE_W-1:0]  out_evp_r, out_evp_nxt;
  logic [COUNT_W-1:0] out_fc_r;

  logic               in_fire;
  logic [PW-1:0]      page_in;
  logic [CAPW-1:0]    cap_raw, cap;
  logic [CNTW-1:0]    count;
  logic               hit, free_found, lru_found, insert, evict;
  logic [RW-1:0]      hit_idx, free_idx, lru_idx, slot;
  logic [RW-1:0]      hit_rank;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    page_in = in_tdata[PW-1:0];
    cap_raw = CAPW'(cap_cfg_r);
    if (cap_raw == '0) begin
      cap = CAPW'(1);
    end else if (cap_raw > CAPW'(FRAMES)) begin
      cap = CAPW'(FRAMES);
    end else begin
      cap = cap_raw;
    end
    count = CNTW'($countones(valid_r));

    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    lru_found  = 1'b0;
    lru_idx    = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!hit && valid_r[i] && page_r[i] == page_in) begin
        hit     = 1'b1;
        hit_idx = RW'(i);
      end
      if (!free_found && !valid_r[i] && CAPW'(i) < cap) begin
        free_found = 1'b1;
        free_idx   = RW'(i);
      end
      if (!lru_found && valid_r[i] && rank_r[i] == '0) begin
        lru_found = 1'b1;
        lru_idx   = RW'(i);
      end
    end

    insert   = !hit && (CAPW'(count) < cap);
    evict    = !hit && !insert;
    slot     = hit ? hit_idx : (insert ? free_idx : lru_idx);
    hit_rank = rank_r[hit_idx];

    page_nxt  = page_r;
    rank_nxt  = rank_r;
    valid_nxt = valid_r;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit && valid_r[i] && rank_r[i] > hit_rank) begin
        rank_nxt[i] = rank_r[i] - 1'b1;
      end
      if (evict && valid_r[i] && RW'(i) != slot && rank_r[i] != '0) begin
        rank_nxt[i] = rank_r[i] - 1'b1;
      end
    end
    if (hit) begin
      rank_nxt[slot] = RW'(count - 1'b1);
    end else if (insert) begin
      valid_nxt[slot] = 1'b1;
      page_nxt[slot]  = page_in;
      rank_nxt[slot]  = RW'(count);
    end else begin
      page_nxt[slot]  = page_in;
      rank_nxt[slot]  = RW'(count - 1'b1);
    end

    if (hit || faults_r == '1) begin
      faults_nxt = faults_r;
    end else begin
      faults_nxt = faults_r + 1'b1;
    end

    out_hit_nxt  = hit;
    out_slot_nxt = SLOT_W'(slot);
    out_ev_nxt   = evict;
    out_evp_nxt  = evict ? PAGE_W'(page_r[slot]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      faults_r    <= '0;
      cap_cfg_r   <= CFG_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        page_r[i] <= '0;
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_cfg_r <= cfg_data;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        if (in_tlast) begin
          valid_r  <= '0;
          faults_r <= '0;
          for (int i = 0; i < FRAMES; i++) begin
            page_r[i] <= '0;
            rank_r[i] <= '0;
          end
        end else begin
          valid_r  <= valid_nxt;
          faults_r <= faults_nxt;
          page_r   <= page_nxt;
          rank_r   <= rank_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_hit_r  <= out_hit_nxt;
      out_slot_r <= out_slot_nxt;
      out_ev_r   <= out_ev_nxt;
      out_evp_r  <= out_evp_nxt;
      out_fc_r   <= faults_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_ev_r, out_hit_r};
  assign out_tdata  = {{(OUT_TDATA_W - FC_MSB - 1){1'b0}}, out_fc_r, out_evp_r, out_slot_r};

endmodule

>>> sv/lrupr_checker.sv
// ----------------------------------------------------------------------------
// lrupr_checker
// port-level checks for the lru page replacement block, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_page_replacement_assert.svh"

module lrupr_checker
  import lrupr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  `LRUPR_ASSERT_HOLD(a_out_hold, clk, rst_n, out_tvalid, out_tready, out_tvalid)
  `LRUPR_ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `LRUPR_ASSERT_IMPL(a_hit_no_evict, clk, rst_n, out_tvalid && out_tuser[TUSER_HIT], !out_tuser[TUSER_EVICT])
  `LRUPR_ASSERT_IMPL(a_evp_zero, clk, rst_n, out_tvalid && !out_tuser[TUSER_EVICT], out_tdata[EVP_MSB:EVP_LSB] == '0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
